// ----- design/sipq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sipq_pkg
// Shared types and constants of the sorted-insert priority queue.
// ----------------------------------------------------------------------------
package sipq_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int VALUE_W   = 32;
    localparam int STATUS_W  = 2;
    localparam int COUNT_W   = 5;

    // Operation codes carried in the input tuser
    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_POP  = 1'b1;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Controller states
    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load;   // capture the input word
        logic exec;   // update the store and load the result register
    } t_dp_cmd;

    // Datapath status, read by the checks in the top level
    typedef struct packed {
        logic empty;
        logic full;
    } t_dp_status;

endpackage

// ----- design/sipq_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sipq_ctrl
// Sequencer: takes one word, runs it through the datapath, holds the result
// until the output side takes it.
// ----------------------------------------------------------------------------
module sipq_ctrl
    import sipq_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_exec_ok;

    // Result slot is free or being emptied this cycle
    assign w_exec_ok = !r_out_valid || i_out_ready;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_exec_ok) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs and commands
    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_EXEC: begin
                o_cmd.exec = w_exec_ok;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    // Result valid: set on execute, clear when taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.exec) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ----- design/sipq_dpath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sipq_dpath
// Row of compare-and-shift cells kept in descending order, largest in cell 0,
// with the fill counter, input capture and result register.
// ----------------------------------------------------------------------------
module sipq_dpath
    import sipq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_dp_cmd                    i_cmd,
    input  logic                       i_kind,
    input  logic signed [VALUE_W-1:0]  i_value,
    output t_dp_status                 o_status,
    output logic signed [VALUE_W-1:0]  o_popped,
    output t_status                    o_result,
    output logic [COUNT_W-1:0]         o_count
);

    localparam int FILL_W = $clog2(DEPTH + 1);

    logic                      r_kind;
    logic signed [VALUE_W-1:0] r_value;
    logic signed [VALUE_W-1:0] r_entry [DEPTH];
    logic signed [VALUE_W-1:0] n_entry [DEPTH];
    logic [FILL_W-1:0]         r_fill;
    logic [FILL_W-1:0]         n_fill;
    logic [DEPTH-1:0]          w_lt;
    logic                      w_empty;
    logic                      w_full;
    logic                      w_push_ok;
    logic                      w_pop_ok;
    t_status                   n_result;
    logic signed [VALUE_W-1:0] n_popped;
    logic [FILL_W+COUNT_W-1:0] w_count_ext;

    logic signed [VALUE_W-1:0] r_popped;
    t_status                   r_result;
    logic [COUNT_W-1:0]        r_count;

    assign w_empty   = (r_fill == '0);
    assign w_full    = (r_fill == FILL_W'(DEPTH));
    assign w_push_ok = (r_kind == KIND_PUSH) && !w_full;
    assign w_pop_ok  = (r_kind == KIND_POP) && !w_empty;

    // Per-cell compare: cell is unused or holds a value below the new one.
    // The row is sorted, so these flags form a thermometer code.
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            w_lt[i] = (FILL_W'(i) >= r_fill) || (r_entry[i] < r_value);
        end
    end

    // Cell update: shift down behind the insert point, or shift up on pop
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            n_entry[i] = r_entry[i];
            if (w_push_ok) begin
                if (i > 0 && w_lt[i-1]) begin
                    n_entry[i] = r_entry[i-1];
                end else if (w_lt[i]) begin
                    n_entry[i] = r_value;
                end
            end else if (w_pop_ok && i < DEPTH - 1) begin
                n_entry[i] = r_entry[i+1];
            end
        end
    end

    // Fill, status and result word
    always_comb begin
        n_fill   = r_fill;
        n_popped = '0;
        n_result = ST_OK;
        if (r_kind == KIND_PUSH) begin
            if (w_full) begin
                n_result = ST_FULL;
            end else begin
                n_fill = r_fill + 1'b1;
            end
        end else begin
            if (w_empty) begin
                n_result = ST_EMPTY;
            end else begin
                n_fill   = r_fill - 1'b1;
                n_popped = r_entry[0];
            end
        end
    end

    // Count reported modulo the field width
    assign w_count_ext = {{COUNT_W{1'b0}}, n_fill};

    // Capture input word
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind  <= i_kind;
            r_value <= i_value;
        end
    end

    // Advance the cells and load the result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_entry  <= n_entry;
            r_popped <= n_popped;
            r_result <= n_result;
            r_count  <= w_count_ext[COUNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_cmd.exec) begin
            r_fill <= n_fill;
        end
    end

    assign o_status.empty = w_empty;
    assign o_status.full  = w_full;
    assign o_popped       = r_popped;
    assign o_result       = r_result;
    assign o_count        = r_count;

endmodule

// ----- design/sorted_insert_priority_queue_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_insert_priority_queue_top
// Priority queue of signed words: push inserts in order, pop returns the
// largest. Each word yields one result with status and count.
// Sequence: the input word is captured, then executed into the result register;
// a new word is taken only after the last one has executed, set by the capture /
// execute sequence around the single row of compare-and-shift cells.
// Reset: synchronous, active low; empties the store and drops any result.
// ----------------------------------------------------------------------------
module sorted_insert_priority_queue_top
    import sipq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [VALUE_W-1:0]  s_axis_tdata,   // [31:0] value
    input  logic                s_axis_tuser,   // [0] kind
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [39:0]         m_axis_tdata,   // [31:0] popped, [36:32] count
    output logic [STATUS_W-1:0] m_axis_tuser    // [1:0] status
);

    t_dp_cmd                   w_cmd;
    t_dp_status                w_dp_status;
    logic signed [VALUE_W-1:0] w_popped;
    t_status                   w_result;
    logic [COUNT_W-1:0]        w_count;

    sipq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (w_cmd)
    );

    sipq_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_kind   (s_axis_tuser),
        .i_value  ($signed(s_axis_tdata)),
        .o_status (w_dp_status),
        .o_popped (w_popped),
        .o_result (w_result),
        .o_count  (w_count)
    );

    // Pack the result word
    assign m_axis_tdata = {3'b000, w_count, w_popped};
    assign m_axis_tuser = w_result;

`ifndef SYNTHESIS
    // An execute always leaves a result waiting
    a_exec_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.exec |=> m_axis_tvalid)
        else $error("execute did not produce a result");

    // One word in flight: intake closes right after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("second word accepted while one is in flight");

    // A pending full-drop result matches a full store
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == ST_FULL) |-> w_dp_status.full)
        else $error("full status with a store that is not full");

    // A pending empty-pop result matches an empty store
    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == ST_EMPTY) |-> w_dp_status.empty)
        else $error("empty status with a store that is not empty");
`endif

endmodule

// ----- sim/tb_sorted_insert_priority_queue_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_insert_priority_queue_top
// Self-checking bench for the sorted-insert priority queue. Every accepted
// push or pop is run through a local model of the sorted store, and each
// result word is compared with the oldest predicted result. Traffic runs
// with no backpressure, with sender gaps, with receiver stalls, and with both.
// ----------------------------------------------------------------------------
module tb_sorted_insert_priority_queue_top;
    import sipq_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 7;
    localparam int TAIL_CYCLES  = 8;
    localparam int PHASE_ITEMS  = 300;
    localparam int SEGMENT_LEN  = 30;

    // Expected contents of one result word
    typedef struct {
        logic [VALUE_W-1:0] popped;
        t_status            status;
        logic [COUNT_W-1:0] count;
    } t_queue_result;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [VALUE_W-1:0]  s_axis_tdata = '0;   // [31:0] value
    logic                s_axis_tuser = KIND_PUSH;   // [0] kind
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [39:0]         m_axis_tdata;   // [31:0] popped, [36:32] count
    logic [STATUS_W-1:0] m_axis_tuser;   // [1:0] status

    // Local copy of the sorted store, ascending from index 0
    logic signed [VALUE_W-1:0] model_entries [DEPTH_DEF];
    int                        model_fill = 0;

    t_queue_result pending_results [$];
    int            fail_count = 0;
    int            src_idle_pct = 0;
    int            snk_stall_pct = 0;

    sorted_insert_priority_queue_top #(
        .DEPTH(DEPTH_DEF)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    initial begin
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    // Apply one operation to the local store and return its result
    function automatic t_queue_result predict_queue_op(logic kind,
                                                       logic signed [VALUE_W-1:0] value);
        t_queue_result res;
        int            pos;
        res.popped = '0;
        res.status = ST_OK;
        if (kind == KIND_PUSH) begin
            if (model_fill >= DEPTH_DEF) begin
                res.status = ST_FULL;
            end else begin
                // insert ahead of the first entry not less than the new value
                pos = model_fill;
                for (int i = model_fill - 1; i >= 0; i--) begin
                    if (model_entries[i] >= value) pos = i;
                end
                for (int i = model_fill; i > pos; i--) begin
                    model_entries[i] = model_entries[i-1];
                end
                model_entries[pos] = value;
                model_fill++;
            end
        end else begin
            if (model_fill == 0) begin
                res.status = ST_EMPTY;
            end else begin
                model_fill--;
                res.popped = model_entries[model_fill];
            end
        end
        res.count = model_fill[COUNT_W-1:0];
        return res;
    endfunction

    // Send one word, with an optional random gap ahead of it
    task automatic send_word(input logic kind, input logic [VALUE_W-1:0] value);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tuser  <= kind;
        do @(posedge i_clk); while (!s_axis_tready);
        pending_results.push_back(predict_queue_op(kind, value));
    endtask

    // Hold the sender until every predicted result has come back
    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    // Random value: mostly full range, some extremes, some narrow band for ties
    function automatic logic [VALUE_W-1:0] pick_value();
        logic [VALUE_W-1:0] v;
        case ($urandom_range(9))
            0:       v = 32'h8000_0000;
            1:       v = 32'h7FFF_FFFF;
            2, 3, 4: v = 32'($urandom_range(15)) - 32'd8;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // Pop on empty, extremes of the value field, ties
    task automatic test_extremes();
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        send_word(KIND_POP, 32'hFFFF_FFFF);
        send_word(KIND_PUSH, 32'h8000_0000);
        send_word(KIND_PUSH, 32'h7FFF_FFFF);
        send_word(KIND_PUSH, 32'h0000_0000);
        send_word(KIND_PUSH, 32'hFFFF_FFFF);
        send_word(KIND_PUSH, 32'd5);
        send_word(KIND_PUSH, 32'd5);
        repeat (3) send_word(KIND_POP, $urandom);
    endtask

    // Fill the store completely, then push once more to hit the full case
    task automatic test_fill_to_full();
        while (model_fill < DEPTH_DEF) send_word(KIND_PUSH, pick_value());
        send_word(KIND_PUSH, 32'h1234_5678);
    endtask

    // Random pushes and pops in segments of varying push bias
    task automatic test_random_traffic(input int idle_pct, input int stall_pct);
        int push_pct;
        src_idle_pct  = idle_pct;
        snk_stall_pct = stall_pct;
        push_pct      = 50;
        for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n % SEGMENT_LEN == 0) begin
                case ($urandom_range(2))
                    0:       push_pct = 80;
                    1:       push_pct = 20;
                    default: push_pct = 50;
                endcase
            end
            if ($urandom_range(99) < push_pct) send_word(KIND_PUSH, pick_value());
            else send_word(KIND_POP, $urandom);
        end
        wait_for_results();
    endtask

    // Drive receiver backpressure
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
    end

    // Compare each accepted result word with the oldest prediction
    always @(posedge i_clk) begin
        t_queue_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result word: popped %0d status %0d count %0d",
                       $signed(m_axis_tdata[31:0]), m_axis_tuser, m_axis_tdata[36:32]);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tdata[31:0] !== want.popped) begin
                    $error("popped: expected %0d, actual %0d",
                           $signed(want.popped), $signed(m_axis_tdata[31:0]));
                    fail_count++;
                end
                if (m_axis_tuser !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, m_axis_tuser);
                    fail_count++;
                end
                if (m_axis_tdata[36:32] !== want.count) begin
                    $error("count: expected %0d, actual %0d", want.count,
                           m_axis_tdata[36:32]);
                    fail_count++;
                end
            end
        end
    end

    // Main sequence
    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_extremes();
        test_fill_to_full();
        wait_for_results();
        test_random_traffic(0, 0);
        test_random_traffic(62, 0);
        test_random_traffic(0, 62);
        test_random_traffic(37, 37);
        if (pending_results.size() != 0) begin
            $error("results still expected at end: %0d", pending_results.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("sorted_insert_priority_queue_top: match");
        end else begin
            $display("sorted_insert_priority_queue_top: mismatch");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5ms;
        $display("sorted_insert_priority_queue_top: mismatch");
        $finish;
    end

endmodule
